[sv/running_median_deviation_cost_assert.svh]
// Assertion macros for the running median deviation cost block.
`ifndef RUNNING_MEDIAN_DEVIATION_COST_ASSERT_SVH
`define RUNNING_MEDIAN_DEVIATION_COST_ASSERT_SVH
`ifndef SYNTHESIS
`define RMDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmdc assertion failed");
`define RMDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmdc assertion failed");
`else
`define RMDC_ASSERT_IMP(lbl, ante, cons)
`define RMDC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/rmdc_pkg.sv]
// Shared types and constants of the running median deviation cost block.
package rmdc_pkg;
  localparam int MAX_PAIRS_DEF = 1024;
  localparam int PT_W = 30;
  localparam int SUM_W = 41;
  localparam int COST_W = 40;

  typedef enum logic {HP_PUSH, HP_REPLACE} hp_op_t;

  typedef struct packed {
    logic go;
    logic clear;
    hp_op_t op;
    logic [PT_W-1:0] val;
  } hp_cmd_t;

  typedef struct packed {
    logic busy;
    logic [PT_W-1:0] top;
  } hp_stat_t;
endpackage

[sv/rmdc_ram.sv]
// Generic single write port, single read port RAM with registered read.
module rmdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[sv/rmdc_heap.sv]
// Binary heap engine over one RAM: push with sift up, replace top with sift down.
module rmdc_heap import rmdc_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF,
  parameter bit IS_MAX = 1'b1
) (
  input  logic     clk,
  input  logic     rst,
  input  hp_cmd_t  cmd,
  output hp_stat_t stat,
  output logic [$clog2(MAX_PAIRS+3)-1:0] count
);
  localparam int SLOTS = MAX_PAIRS + 2;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {E_IDLE, E_PUSH, E_FIN, E_REP, E_LEFT, E_RIGHT} est_t;

  est_t state, state_next;
  logic [CW-1:0] n, n_next;
  logic [AW-1:0] idx, idx_next, par, par_next;
  logic [PT_W-1:0] val, val_next, cl, cl_next, top;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [PT_W-1:0] wdata, rdata, bv;
  logic [AW-1:0] bi;
  logic [CW:0] l_ext, r_ext, n_ext;
  logic l_ok, r_ok;

  function automatic logic ranks_ahead(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y);
    ranks_ahead = IS_MAX ? (x > y) : (x < y);
  endfunction

  rmdc_ram #(.WIDTH(PT_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign l_ext = (CW+1)'({idx, 1'b1});
  assign r_ext = l_ext + (CW+1)'(1);
  assign n_ext = (CW+1)'(n);
  assign l_ok = l_ext < n_ext;
  assign r_ok = r_ext < n_ext;

  always_comb begin
    state_next = state;
    n_next = n;
    idx_next = idx;
    par_next = par;
    val_next = val;
    cl_next = cl;
    we = 1'b0;
    waddr = idx;
    wdata = val;
    re = 1'b0;
    raddr = par;
    bv = cl;
    bi = AW'(l_ext);
    unique case (state)
      E_IDLE: begin
        if (cmd.clear) begin
          n_next = '0;
        end else if (cmd.go) begin
          val_next = cmd.val;
          if (cmd.op == HP_PUSH) begin
            n_next = n + CW'(1);
            if (n == '0) begin
              we = 1'b1;
              waddr = '0;
              wdata = cmd.val;
            end else begin
              idx_next = AW'(n);
              par_next = AW'((n - CW'(1)) >> 1);
              re = 1'b1;
              raddr = AW'((n - CW'(1)) >> 1);
              state_next = E_PUSH;
            end
          end else begin
            idx_next = '0;
            state_next = E_REP;
          end
        end
      end
      E_PUSH: begin
        we = 1'b1;
        if (ranks_ahead(val, rdata)) begin
          wdata = rdata;
          idx_next = par;
          if (par == '0) begin
            state_next = E_FIN;
          end else begin
            par_next = (par - AW'(1)) >> 1;
            re = 1'b1;
            raddr = (par - AW'(1)) >> 1;
          end
        end else begin
          state_next = E_IDLE;
        end
      end
      E_FIN: begin
        we = 1'b1;
        state_next = E_IDLE;
      end
      E_REP: begin
        if (l_ok) begin
          re = 1'b1;
          raddr = AW'(l_ext);
          state_next = E_LEFT;
        end else begin
          we = 1'b1;
          state_next = E_IDLE;
        end
      end
      E_LEFT: begin
        cl_next = rdata;
        if (r_ok) begin
          re = 1'b1;
          raddr = AW'(r_ext);
          state_next = E_RIGHT;
        end else if (ranks_ahead(rdata, val)) begin
          we = 1'b1;
          wdata = rdata;
          idx_next = AW'(l_ext);
          state_next = E_REP;
        end else begin
          we = 1'b1;
          state_next = E_IDLE;
        end
      end
      E_RIGHT: begin
        if (ranks_ahead(rdata, cl)) begin
          bv = rdata;
          bi = AW'(r_ext);
        end
        we = 1'b1;
        if (ranks_ahead(bv, val)) begin
          wdata = bv;
          idx_next = bi;
          state_next = E_REP;
        end else begin
          state_next = E_IDLE;
        end
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      n <= '0;
    end else begin
      state <= state_next;
      n <= n_next;
    end
    idx <= idx_next;
    par <= par_next;
    val <= val_next;
    cl <= cl_next;
    if (we && waddr == '0) begin
      top <= wdata;
    end
  end

  assign stat.busy = (state != E_IDLE);
  assign stat.top = top;
  assign count = n;
endmodule

[sv/running_median_deviation_cost.sv]
// Top level of the running median deviation cost block.
// Input channel: point_a, point_b and restart under in_valid / in_ready.
// Output channel: cost and refused under out_valid / out_ready, one item
// for every input item, in order.
// A lower max-heap and an upper min-heap each live in one RAM; a heap engine
// per RAM sifts one level every cycle (push) or one per E_REP, E_LEFT, E_RIGHT pass (replace).
// An item takes three heap phases: move the larger point or the old lower
// top up, push the smaller point down, then swap the tops if they cross.
// One item is worked on at a time; in_ready is high only while idle.
// A refused item (heaps full, no restart) goes straight from idle to the output state.
// Reset empties both heaps and zeroes the sums; RAM contents need no clearing.
// The result sits in an output register; a stalled receiver holds it, and
// a new item is accepted meanwhile, its result waiting until the slot frees.
module running_median_deviation_cost import rmdc_pkg::*; #(
  parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PT_W-1:0]   point_a,
  input  logic [PT_W-1:0]   point_b,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COST_W-1:0] cost,
  output logic              refused
);
  `include "running_median_deviation_cost_assert.svh"

  localparam int PW = $clog2(MAX_PAIRS + 1);
  localparam int CW = $clog2(MAX_PAIRS + 3);

  typedef enum logic [2:0] {T_IDLE, T_MOVE, T_W1, T_SWAP, T_W2, T_OUT} tst_t;

  tst_t state;
  hp_cmd_t lo_cmd, up_cmd;
  hp_stat_t lo_stat, up_stat;
  logic [CW-1:0] lo_count, up_count;
  logic [PW-1:0] pc;
  logic [SUM_W-1:0] lower_sum, upper_sum;
  logic [PT_W-1:0] m_r, s_r, moved;
  logic pend, refused_r, take_m, do_swap, idle_both, accept;

  rmdc_heap #(.MAX_PAIRS(MAX_PAIRS), .IS_MAX(1'b1)) u_lower (
    .clk(clk), .rst(rst), .cmd(lo_cmd), .stat(lo_stat), .count(lo_count)
  );
  rmdc_heap #(.MAX_PAIRS(MAX_PAIRS), .IS_MAX(1'b0)) u_upper (
    .clk(clk), .rst(rst), .cmd(up_cmd), .stat(up_stat), .count(up_count)
  );

  assign in_ready = (state == T_IDLE);
  assign accept = in_valid && in_ready;
  assign idle_both = !lo_stat.busy && !up_stat.busy;
  assign take_m = (pc == '0) || (m_r >= lo_stat.top);
  assign moved = take_m ? m_r : lo_stat.top;
  assign do_swap = lo_stat.top > up_stat.top;

  always_comb begin
    lo_cmd = '0;
    up_cmd = '0;
    unique case (state)
      T_IDLE: begin
        lo_cmd.clear = accept && restart;
        up_cmd.clear = accept && restart;
      end
      T_MOVE: begin
        up_cmd.go = 1'b1;
        up_cmd.op = HP_PUSH;
        up_cmd.val = moved;
        lo_cmd.go = 1'b1;
        lo_cmd.op = take_m ? HP_PUSH : HP_REPLACE;
        lo_cmd.val = take_m ? s_r : m_r;
      end
      T_W1: begin
        lo_cmd.go = idle_both && pend;
        lo_cmd.op = HP_PUSH;
        lo_cmd.val = s_r;
      end
      T_SWAP: begin
        lo_cmd.go = do_swap;
        lo_cmd.op = HP_REPLACE;
        lo_cmd.val = up_stat.top;
        up_cmd.go = do_swap;
        up_cmd.op = HP_REPLACE;
        up_cmd.val = lo_stat.top;
      end
      T_W2, T_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      out_valid <= 1'b0;
      pc <= '0;
      lower_sum <= '0;
      upper_sum <= '0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != T_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            m_r <= (point_a > point_b) ? point_a : point_b;
            s_r <= (point_a > point_b) ? point_b : point_a;
            if (restart) begin
              pc <= '0;
              lower_sum <= '0;
              upper_sum <= '0;
            end
            if (!restart && pc == PW'(MAX_PAIRS)) begin
              refused_r <= 1'b1;
              state <= T_OUT;
            end else begin
              refused_r <= 1'b0;
              state <= T_MOVE;
            end
          end
        end
        T_MOVE: begin
          pend <= !take_m;
          lower_sum <= lower_sum + SUM_W'(m_r) + SUM_W'(s_r) - SUM_W'(moved);
          upper_sum <= upper_sum + SUM_W'(moved);
          state <= T_W1;
        end
        T_W1: begin
          if (idle_both) begin
            if (pend) begin
              pend <= 1'b0;
            end else begin
              state <= T_SWAP;
            end
          end
        end
        T_SWAP: begin
          if (do_swap) begin
            lower_sum <= lower_sum + SUM_W'(up_stat.top) - SUM_W'(lo_stat.top);
            upper_sum <= upper_sum + SUM_W'(lo_stat.top) - SUM_W'(up_stat.top);
          end
          pc <= pc + PW'(1);
          state <= T_W2;
        end
        T_W2: begin
          if (idle_both) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            cost <= COST_W'(upper_sum - lower_sum);
            refused <= refused_r;
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `RMDC_ASSERT_IMP(a_ready_idle, in_ready, !lo_stat.busy && !up_stat.busy)
  `RMDC_ASSERT_IMP(a_counts, in_ready, lo_count == CW'(pc) && up_count == CW'(pc))
  `RMDC_ASSERT_NXT(a_refused_full, accept && !restart && pc == PW'(MAX_PAIRS), refused_r)
  `RMDC_ASSERT_NXT(a_swap_order, state == T_W2 && idle_both, lo_stat.top <= up_stat.top)
endmodule
